// ----- rtl/acm_pkg.sv -----
`timescale 1ns / 1ps
package acm_pkg;
	localparam int NODES      = 4096;
	localparam int PATTERNS   = 64;
	localparam int ALPHABET   = 26;
	localparam int COUNT_BITS = 20;

	localparam int NODE_W     = $clog2(NODES);
	localparam int CHAR_W     = 5;
	localparam int PAT_W      = 7;
	localparam int CNT_W      = COUNT_BITS;
	localparam int GOTO_DEPTH = NODES * ALPHABET;
	localparam int GA_W       = $clog2(GOTO_DEPTH);
	localparam int CNT_DEPTH  = PATTERNS + 1;
	localparam int CA_W       = $clog2(CNT_DEPTH);

	typedef enum logic [2:0] {
		REQ_CLEAR  = 3'd0,
		REQ_PLET   = 3'd1,
		REQ_ENDP   = 3'd2,
		REQ_BUILD  = 3'd3,
		REQ_TEXT   = 3'd4,
		REQ_REPORT = 3'd5
	} acm_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_PL_WT,
		ST_B0_RD,
		ST_B0_WT,
		ST_BQ_RD,
		ST_BQ_WT,
		ST_BF_WT,
		ST_BC_RD,
		ST_BC_WT,
		ST_BC_WR,
		ST_T_WT,
		ST_T_MW,
		ST_T_CW,
		ST_RMX_RD,
		ST_RMX_WT,
		ST_RSC_RD,
		ST_RSC_WT,
		ST_RFIN,
		ST_EMIT
	} acm_state_t;

	function automatic logic [GA_W-1:0] goto_addr(input logic [NODE_W-1:0] n,
		input logic [CHAR_W-1:0] c);
		return GA_W'(n) * GA_W'(ALPHABET) + GA_W'(c);
	endfunction
endpackage

// ----- rtl/acm_ram.sv -----
`timescale 1ns / 1ps
module acm_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/aho_corasick_match_counter.sv -----
`timescale 1ns / 1ps
// Clear sweeps the root row; a pattern letter reads its goto entry and, when a node is made,
// sweeps the new row; end of pattern is taken in idle; build walks the root row, then every
// queued node and each of its goto entries; a text letter follows the fail chain, with one more
// step per marked node; report makes a max pass and a scan pass over the patterns plus one emit
// per result (a single result with no patterns). One request at a time: s_tready is high only in idle.
// Reset: async active low clears control state, then a clearing pass zeroes the root row.
module aho_corasick_match_counter
	import acm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] char_code, [7:5] zero
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [6:0] pattern_index, [26:7] hit_count, [27] overflow
	output logic        m_tlast
);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	acm_state_t state_q, state_d, ret_q;

	// control registers
	logic [NODE_W-1:0] node_cnt_q, cursor_q, sweep_node_q;
	logic [NODE_W-1:0] head_q, tail_q, now_q, fl_q, child_q, j_q;
	logic [PAT_W-1:0]  pat_cnt_q, m_q, p_q, prev_q, emit_idx_q;
	logic [CHAR_W-1:0] chr_q, bc_q;
	logic              ovf_q, built_q, discard_q, have_prev_q, emit_last_q;
	logic [CNT_W-1:0]  best_q;
	logic [CNT_DEPTH-1:0] cnt_vld_q;
	logic              cnt_vld_rd_q;

	// output register
	logic              out_vld_q, out_ovf_q, out_last_q;
	logic [PAT_W-1:0]  out_idx_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// memory ports
	logic              g_we, f_we, k_we, q_we, c_we;
	logic [GA_W-1:0]   g_waddr, g_raddr;
	logic [NODE_W-1:0] g_wdata, g_rdata;
	logic [NODE_W-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
	logic [NODE_W-1:0] k_waddr, k_raddr;
	logic [PAT_W-1:0]  k_wdata, k_rdata;
	logic [NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
	logic [CA_W-1:0]   c_waddr, c_raddr;
	logic [CNT_W-1:0]  c_wdata, c_rdata;

	logic              accept, out_free, chr_ok;
	acm_req_t          req;
	logic [CHAR_W-1:0] in_chr;
	logic [CNT_W-1:0]  cnt_val;
	logic              p_done, full_nodes;

	assign accept     = s_tvalid && s_tready;
	assign req        = acm_req_t'(s_tuser);
	assign in_chr     = s_tdata[CHAR_W-1:0];
	assign chr_ok     = (in_chr < CHAR_W'(ALPHABET));
	assign out_free   = !out_vld_q || m_tready;
	assign cnt_val    = cnt_vld_rd_q ? c_rdata : '0;
	assign p_done     = (p_q == pat_cnt_q);
	assign full_nodes = (node_cnt_q == NODE_W'(NODES - 1));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_ovf_q, out_cnt_q, out_idx_q};
	assign m_tlast  = out_last_q;

	acm_ram #(.DEPTH(GOTO_DEPTH), .WIDTH(NODE_W)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
	);
	acm_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
	);
	acm_ram #(.DEPTH(NODES), .WIDTH(PAT_W)) u_mark (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
	);
	acm_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
	);
	acm_ram #(.DEPTH(CNT_DEPTH), .WIDTH(CNT_W)) u_cnt (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req)
						REQ_CLEAR:  state_d = ST_SWEEP;
						REQ_PLET:   if (!built_q && !discard_q && chr_ok) state_d = ST_PL_WT;
						REQ_BUILD:  if (!built_q) state_d = ST_B0_RD;
						REQ_TEXT:   if (built_q && chr_ok) state_d = ST_T_WT;
						REQ_REPORT: state_d = (pat_cnt_q == '0) ? ST_EMIT : ST_RMX_RD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SWEEP:  if (bc_q == CHAR_W'(ALPHABET - 1)) state_d = ST_IDLE;
			ST_PL_WT:  state_d = (g_rdata == '0 && !full_nodes) ? ST_SWEEP : ST_IDLE;
			ST_B0_RD:  state_d = ST_B0_WT;
			ST_B0_WT:  state_d = (bc_q == CHAR_W'(ALPHABET - 1)) ? ST_BQ_RD : ST_B0_RD;
			ST_BQ_RD:  state_d = (head_q == tail_q) ? ST_IDLE : ST_BQ_WT;
			ST_BQ_WT:  state_d = ST_BF_WT;
			ST_BF_WT:  state_d = ST_BC_RD;
			ST_BC_RD:  state_d = ST_BC_WT;
			ST_BC_WT:  state_d = ST_BC_WR;
			ST_BC_WR:  state_d = (bc_q == CHAR_W'(ALPHABET - 1)) ? ST_BQ_RD : ST_BC_RD;
			ST_T_WT:   state_d = (g_rdata == '0) ? ST_IDLE : ST_T_MW;
			ST_T_MW: begin
				if (k_rdata != '0) state_d = ST_T_CW;
				else if (f_rdata == '0) state_d = ST_IDLE;
				else state_d = ST_T_MW;
			end
			ST_T_CW:   state_d = (j_q == '0) ? ST_IDLE : ST_T_MW;
			ST_RMX_RD: state_d = ST_RMX_WT;
			ST_RMX_WT: state_d = p_done ? ST_RSC_RD : ST_RMX_RD;
			ST_RSC_RD: state_d = ST_RSC_WT;
			ST_RSC_WT: begin
				if (cnt_val == best_q && have_prev_q) state_d = ST_EMIT;
				else state_d = p_done ? ST_RFIN : ST_RSC_RD;
			end
			ST_RFIN:   state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = ret_q;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
		f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
		k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = '0;
		q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
		c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				g_raddr = goto_addr(cursor_q, in_chr);
				if (accept && req == REQ_ENDP && !built_q && pat_cnt_q < PAT_W'(PATTERNS)
					&& !discard_q) begin
					k_we    = 1'b1;
					k_waddr = cursor_q;
					k_wdata = pat_cnt_q + 1'b1;
				end
			end
			ST_SWEEP: begin
				g_we    = 1'b1;
				g_waddr = goto_addr(sweep_node_q, bc_q);
				if (bc_q == '0) begin
					f_we    = 1'b1;
					f_waddr = sweep_node_q;
					k_we    = 1'b1;
					k_waddr = sweep_node_q;
				end
			end
			ST_PL_WT: begin
				// link the new node in; its row is swept next
				if (g_rdata == '0 && !full_nodes) begin
					g_we    = 1'b1;
					g_waddr = goto_addr(cursor_q, chr_q);
					g_wdata = node_cnt_q + 1'b1;
				end
			end
			ST_B0_RD: g_raddr = goto_addr('0, bc_q);
			ST_B0_WT: begin
				if (g_rdata != '0) begin
					f_we    = 1'b1;
					f_waddr = g_rdata;
					q_we    = 1'b1;
					q_waddr = tail_q;
					q_wdata = g_rdata;
				end
			end
			ST_BQ_RD: q_raddr = head_q;
			ST_BQ_WT: f_raddr = q_rdata;
			ST_BC_RD: g_raddr = goto_addr(now_q, bc_q);
			ST_BC_WT: g_raddr = goto_addr(fl_q, bc_q);
			ST_BC_WR: begin
				if (child_q != '0) begin
					f_we    = 1'b1;
					f_waddr = child_q;
					f_wdata = g_rdata;
					q_we    = 1'b1;
					q_waddr = tail_q;
					q_wdata = child_q;
				end else begin
					g_we    = 1'b1;
					g_waddr = goto_addr(now_q, bc_q);
					g_wdata = g_rdata;
				end
			end
			ST_T_WT: begin
				k_raddr = g_rdata;
				f_raddr = g_rdata;
			end
			ST_T_MW: begin
				c_raddr = CA_W'(k_rdata);
				k_raddr = f_rdata;
				f_raddr = f_rdata;
			end
			ST_T_CW: begin
				k_raddr = j_q;
				f_raddr = j_q;
				if (cnt_val != CNT_MAX) begin
					c_we    = 1'b1;
					c_waddr = CA_W'(m_q);
					c_wdata = cnt_val + 1'b1;
				end
			end
			ST_RMX_RD: c_raddr = CA_W'(p_q);
			ST_RSC_RD: c_raddr = CA_W'(p_q);
			default: ;
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			ret_q        <= ST_IDLE;
			node_cnt_q   <= '0;
			cursor_q     <= '0;
			sweep_node_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			now_q        <= '0;
			fl_q         <= '0;
			child_q      <= '0;
			j_q          <= '0;
			pat_cnt_q    <= '0;
			m_q          <= '0;
			p_q          <= '0;
			prev_q       <= '0;
			emit_idx_q   <= '0;
			chr_q        <= '0;
			bc_q         <= '0;
			ovf_q        <= 1'b0;
			built_q      <= 1'b0;
			discard_q    <= 1'b0;
			have_prev_q  <= 1'b0;
			emit_last_q  <= 1'b0;
			best_q       <= '0;
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
			out_vld_q    <= 1'b0;
			out_ovf_q    <= 1'b0;
			out_last_q   <= 1'b0;
			out_idx_q    <= '0;
			out_cnt_q    <= '0;
		end else begin
			state_q      <= state_d;
			cnt_vld_rd_q <= cnt_vld_q[c_raddr];
			if (c_we) cnt_vld_q[c_waddr] <= 1'b1;
			// load a result on emit, else drop it once the receiver takes it
			if (state_q == ST_EMIT && out_free) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					chr_q <= in_chr;
					if (accept) begin
						case (req)
							REQ_CLEAR: begin
								cnt_vld_q    <= '0;
								node_cnt_q   <= '0;
								pat_cnt_q    <= '0;
								cursor_q     <= '0;
								ovf_q        <= 1'b0;
								built_q      <= 1'b0;
								discard_q    <= 1'b0;
								sweep_node_q <= '0;
								bc_q         <= '0;
							end
							REQ_ENDP: begin
								if (!built_q) begin
									if (pat_cnt_q >= PAT_W'(PATTERNS)) ovf_q <= 1'b1;
									else pat_cnt_q <= pat_cnt_q + 1'b1;
									cursor_q  <= '0;
									discard_q <= 1'b0;
								end
							end
							REQ_BUILD: begin
								bc_q   <= '0;
								head_q <= '0;
								tail_q <= '0;
							end
							REQ_REPORT: begin
								// report setup; with no patterns these give a single empty result
								p_q         <= PAT_W'(1);
								best_q      <= '0;
								have_prev_q <= 1'b0;
								emit_idx_q  <= '0;
								emit_last_q <= 1'b1;
								ret_q       <= ST_IDLE;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: bc_q <= bc_q + 1'b1;
				ST_PL_WT: begin
					if (g_rdata != '0) begin
						cursor_q <= g_rdata;
					end else if (full_nodes) begin
						ovf_q     <= 1'b1;
						discard_q <= 1'b1;
					end else begin
						node_cnt_q   <= node_cnt_q + 1'b1;
						cursor_q     <= node_cnt_q + 1'b1;
						sweep_node_q <= node_cnt_q + 1'b1;
						bc_q         <= '0;
					end
				end
				ST_B0_WT: begin
					if (g_rdata != '0) tail_q <= tail_q + 1'b1;
					bc_q <= (bc_q == CHAR_W'(ALPHABET - 1)) ? '0 : bc_q + 1'b1;
				end
				ST_BQ_RD: begin
					if (head_q == tail_q) begin
						built_q  <= 1'b1;
						cursor_q <= '0;
					end else begin
						head_q <= head_q + 1'b1;
					end
				end
				ST_BQ_WT: now_q <= q_rdata;
				ST_BF_WT: begin
					fl_q <= f_rdata;
					bc_q <= '0;
				end
				ST_BC_WT: child_q <= g_rdata;
				ST_BC_WR: begin
					if (child_q != '0) tail_q <= tail_q + 1'b1;
					bc_q <= (bc_q == CHAR_W'(ALPHABET - 1)) ? '0 : bc_q + 1'b1;
				end
				ST_T_WT: cursor_q <= g_rdata;
				ST_T_MW: begin
					m_q <= k_rdata;
					j_q <= f_rdata;
				end
				ST_RMX_WT: begin
					if (cnt_val > best_q) best_q <= cnt_val;
					p_q <= p_done ? PAT_W'(1) : p_q + 1'b1;
				end
				ST_RSC_WT: begin
					if (cnt_val == best_q) begin
						prev_q      <= p_q;
						have_prev_q <= 1'b1;
						if (have_prev_q) begin
							emit_idx_q  <= prev_q;
							emit_last_q <= 1'b0;
							ret_q       <= p_done ? ST_RFIN : ST_RSC_RD;
						end
					end
					if (!p_done) p_q <= p_q + 1'b1;
				end
				ST_RFIN: begin
					emit_idx_q  <= prev_q;
					emit_last_q <= 1'b1;
					ret_q       <= ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_idx_q  <= emit_idx_q;
						out_cnt_q  <= best_q;
						out_ovf_q  <= ovf_q;
						out_last_q <= emit_last_q;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// queue read pointer never passes the write pointer
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BQ_RD |-> head_q <= tail_q)
		else $error("bfs head passed tail");
	// every queued node exists
	a_tail_nodes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BQ_RD |-> tail_q <= node_cnt_q)
		else $error("bfs queue longer than trie");
	// cursor stays on an allocated node
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= node_cnt_q)
		else $error("cursor beyond allocated nodes");
`endif
endmodule
